FILE: design/tqt_pkg.sv
package tqt_pkg;

    // Default table depth.
    localparam int DEPTH_DEF = 16;

    // Command codes.
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP       = 3'd2;
    localparam logic [2:0] CMD_FIND      = 3'd3;
    localparam logic [2:0] CMD_DELETE    = 3'd4;
    localparam logic [2:0] CMD_SORT      = 3'd5;
    localparam logic [2:0] CMD_REVERSE   = 3'd6;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // One table entry as stored in the RAM.
    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] task_addr;
        logic [31:0] regs;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: design/tqt_ram.sv
module tqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/task_queue_table.sv
// Ordered task table of up to DEPTH entries held in one RAM with one write
// port and one registered read port.
// Input channel: i_valid, o_stall, with i_cmd, i_key_id, i_task_addr and
// i_reg_word. A command word is taken only while the sequencer is idle;
// o_stall is high for as long as a command is being worked on.
// Output channel: o_valid, i_stall, one result word per command with status,
// the found or removed entry, the entry count and the empty flag.
// Every entry that moves costs a RAM read step and a RAM write step, since
// the sequencer has one RAM read port; insert back writes the new entry at
// once as the command is taken. The next command word can be taken in the
// cycle after the result is loaded.
// The output register holds a result while the receiver stalls; a new
// command may be taken meanwhile, and its result waits in the last sequencer
// step until the output register is free.
// Reset clears the entry count, the sequencer and the output valid; RAM
// contents are not cleared, and no entry at or above the count is used.
module task_queue_table #(
    parameter int DEPTH = tqt_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_key_id,
    input  logic [31:0] i_task_addr,
    input  logic [31:0] i_reg_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_out_id,
    output logic [31:0] o_out_task,
    output logic [31:0] o_out_regs,
    output logic [4:0]  o_entry_count,
    output logic        o_is_empty
);
    import tqt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SHR   = 4'd1;
    localparam logic [3:0] S_SHW   = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_FCHK  = 4'd4;
    localparam logic [3:0] S_SLR   = 4'd5;
    localparam logic [3:0] S_SLW   = 4'd6;
    localparam logic [3:0] S_SORT0 = 4'd7;
    localparam logic [3:0] S_SORT1 = 4'd8;
    localparam logic [3:0] S_SRD   = 4'd9;
    localparam logic [3:0] S_SCMP  = 4'd10;
    localparam logic [3:0] S_RVA   = 4'd11;
    localparam logic [3:0] S_RVB   = 4'd12;
    localparam logic [3:0] S_RVW1  = 4'd13;
    localparam logic [3:0] S_RVW2  = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0]    r_state, n_state;
    logic [2:0]    r_cmd, n_cmd;
    t_entry        r_key, n_key;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_lim, n_lim;
    t_entry        r_cur, n_cur;
    t_entry        r_res, n_res;
    logic [1:0]    r_st, n_st;

    logic          r_o_valid, n_o_valid;
    logic [1:0]    r_o_status, n_o_status;
    t_entry        r_o_ent, n_o_ent;
    logic [CW-1:0] r_o_cnt, n_o_cnt;

    logic          ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    t_entry        ram_wd, ram_rd;
    logic [CW-1:0] idx_m1, idx_p1, j_p1, lim_m1, cnt_m1;
    logic [CW+4:0] cnt_ext;

    tqt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(ram_ra),
        .o_rdata(ram_rd)
    );

    assign idx_m1 = r_idx - 1'b1;
    assign idx_p1 = r_idx + 1'b1;
    assign j_p1   = r_j + 1'b1;
    assign lim_m1 = r_lim - 1'b1;
    assign cnt_m1 = r_cnt - 1'b1;

    // Sequencer: every step issues at most one RAM read and one RAM write.
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_j        = r_j;
        n_lim      = r_lim;
        n_cur      = r_cur;
        n_res      = r_res;
        n_st       = r_st;
        n_o_valid  = r_o_valid & i_stall;
        n_o_status = r_o_status;
        n_o_ent    = r_o_ent;
        n_o_cnt    = r_o_cnt;
        ram_we     = 1'b0;
        ram_wa     = r_idx[AW-1:0];
        ram_wd     = r_cur;
        ram_ra     = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd = i_cmd;
                    n_key = '{id: i_key_id, task_addr: i_task_addr, regs: i_reg_word};
                    n_res = '0;
                    n_st  = ST_OK;
                    n_idx = '0;
                    n_state = S_DONE;
                    case (i_cmd)
                        CMD_INS_FRONT, CMD_INS_BACK: begin
                            if (r_cnt == CW'(DEPTH)) begin
                                n_st = ST_FULL;
                            end else if (i_cmd == CMD_INS_FRONT) begin
                                n_idx   = r_cnt;
                                n_state = S_SHR;
                            end else begin
                                ram_we = 1'b1;
                                ram_wa = r_cnt[AW-1:0];
                                ram_wd = '{id: i_key_id, task_addr: i_task_addr,
                                           regs: i_reg_word};
                                n_cnt  = r_cnt + 1'b1;
                            end
                        end
                        CMD_POP, CMD_FIND, CMD_DELETE: begin
                            n_state = S_FRD;
                        end
                        CMD_SORT: begin
                            n_lim   = r_cnt;
                            n_state = S_SORT0;
                        end
                        CMD_REVERSE: begin
                            n_j = cnt_m1;
                            if (r_cnt > CW'(1)) begin
                                n_state = S_RVA;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Front insert: move entries up one place from the back.
            S_SHR: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    ram_wa  = '0;
                    ram_wd  = r_key;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_ra  = idx_m1[AW-1:0];
                    n_state = S_SHW;
                end
            end
            S_SHW: begin
                ram_we  = 1'b1;
                ram_wa  = r_idx[AW-1:0];
                ram_wd  = ram_rd;
                n_idx   = idx_m1;
                n_state = S_SHR;
            end

            // Walk from the front for the first match; pop takes position 0.
            S_FRD: begin
                if (r_idx == r_cnt) begin
                    n_st    = ST_NOTFOUND;
                    n_state = S_DONE;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (r_cmd == CMD_POP || ram_rd.id == r_key.id) begin
                    n_res = ram_rd;
                    if (r_cmd == CMD_FIND) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = idx_p1;
                        n_state = S_SLR;
                    end
                end else begin
                    n_idx   = idx_p1;
                    n_state = S_FRD;
                end
            end

            // Close the gap: move entries down one place.
            S_SLR: begin
                if (r_idx == r_cnt) begin
                    n_cnt   = cnt_m1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SLW;
                end
            end
            S_SLW: begin
                ram_we  = 1'b1;
                ram_wa  = idx_m1[AW-1:0];
                ram_wd  = ram_rd;
                n_idx   = idx_p1;
                n_state = S_SLR;
            end

            // Bubble pass: carry the largest entry so far toward the back.
            S_SORT0: begin
                if (r_lim <= CW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    ram_ra  = '0;
                    n_j     = '0;
                    n_state = S_SORT1;
                end
            end
            S_SORT1: begin
                n_cur   = ram_rd;
                n_state = S_SRD;
            end
            S_SRD: begin
                if (j_p1 == r_lim) begin
                    ram_we  = 1'b1;
                    ram_wa  = lim_m1[AW-1:0];
                    ram_wd  = r_cur;
                    n_lim   = lim_m1;
                    n_state = S_SORT0;
                end else begin
                    ram_ra  = j_p1[AW-1:0];
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                ram_we = 1'b1;
                ram_wa = r_j[AW-1:0];
                if (r_cur.task_addr > ram_rd.task_addr) begin
                    ram_wd = ram_rd;
                end else begin
                    ram_wd = r_cur;
                    n_cur  = ram_rd;
                end
                n_j     = j_p1;
                n_state = S_SRD;
            end

            // Reverse: swap the two ends and move inward.
            S_RVA: begin
                if (r_idx >= r_j) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RVB;
                end
            end
            S_RVB: begin
                n_cur   = ram_rd;
                ram_ra  = r_j[AW-1:0];
                n_state = S_RVW1;
            end
            S_RVW1: begin
                ram_we  = 1'b1;
                ram_wa  = r_idx[AW-1:0];
                ram_wd  = ram_rd;
                n_state = S_RVW2;
            end
            S_RVW2: begin
                ram_we  = 1'b1;
                ram_wa  = r_j[AW-1:0];
                ram_wd  = r_cur;
                n_idx   = idx_p1;
                n_j     = r_j - 1'b1;
                n_state = S_RVA;
            end

            // Hand the result word to the output register once it is free.
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_st;
                    n_o_ent    = r_res;
                    n_o_cnt    = r_cnt;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_j        <= n_j;
        r_lim      <= n_lim;
        r_cur      <= n_cur;
        r_res      <= n_res;
        r_st       <= n_st;
        r_o_status <= n_o_status;
        r_o_ent    <= n_o_ent;
        r_o_cnt    <= n_o_cnt;
    end

    assign cnt_ext       = {5'd0, r_o_cnt};
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_out_id      = r_o_ent.id;
    assign o_out_task    = r_o_ent.task_addr;
    assign o_out_regs    = r_o_ent.regs;
    assign o_entry_count = cnt_ext[4:0];
    assign o_is_empty    = (r_o_cnt == '0);

endmodule

FILE: bench/tb_task_queue_table.sv
`timescale 1ns / 1ps

module tb_task_queue_table;
    import tqt_pkg::*;

    localparam int TBL_DEPTH = DEPTH_DEF;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  id;
        logic [31:0] task_addr;
        logic [31:0] regs;
        logic [4:0]  count;
        logic        empty;
    } t_result;

    // Scoreboard: keeps its own copy of the table and a queue of expected words.
    class table_scoreboard;
        t_entry  rows[$];
        t_result pending[$];
        int      errors;
        int      checked;

        function void note_command(logic [2:0] cmd, logic [7:0] id,
                                   logic [31:0] taddr, logic [31:0] regs);
            t_result r;
            t_entry  e;
            t_entry  tmp;
            int      pos;
            r = '0;
            e.id = id;
            e.task_addr = taddr;
            e.regs = regs;
            case (cmd)
                CMD_INS_FRONT, CMD_INS_BACK: begin
                    if (rows.size() >= TBL_DEPTH) begin
                        r.status = ST_FULL;
                    end else if (cmd == CMD_INS_FRONT) begin
                        rows.push_front(e);
                    end else begin
                        rows.push_back(e);
                    end
                end
                CMD_POP, CMD_FIND, CMD_DELETE: begin
                    pos = -1;
                    if (cmd == CMD_POP) begin
                        if (rows.size() > 0) pos = 0;
                    end else begin
                        for (int i = 0; i < rows.size(); i++) begin
                            if (pos < 0 && rows[i].id == id) pos = i;
                        end
                    end
                    if (pos < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.id = rows[pos].id;
                        r.task_addr = rows[pos].task_addr;
                        r.regs = rows[pos].regs;
                        if (cmd != CMD_FIND) rows.delete(pos);
                    end
                end
                CMD_SORT: begin
                    // Stable bubble sort on the task address.
                    for (int n = rows.size(); n > 1; n--) begin
                        for (int j = 0; j + 1 < n; j++) begin
                            if (rows[j].task_addr > rows[j+1].task_addr) begin
                                tmp = rows[j];
                                rows[j] = rows[j+1];
                                rows[j+1] = tmp;
                            end
                        end
                    end
                end
                CMD_REVERSE: rows.reverse();
                default: ;
            endcase
            r.count = 5'(rows.size());
            r.empty = (rows.size() == 0);
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: result word with nothing expected, got %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            if (got.id !== want.id)
                $display("%0t: out_id expected %h actual %h", $time, want.id, got.id);
            if (got.task_addr !== want.task_addr)
                $display("%0t: out_task expected %h actual %h", $time,
                         want.task_addr, got.task_addr);
            if (got.regs !== want.regs)
                $display("%0t: out_regs expected %h actual %h", $time, want.regs, got.regs);
            if (got.count !== want.count)
                $display("%0t: entry_count expected %0d actual %0d", $time,
                         want.count, got.count);
            if (got.empty !== want.empty)
                $display("%0t: is_empty expected %0d actual %0d", $time, want.empty, got.empty);
            if (got !== want) errors++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_cmd;
    logic [7:0]  i_key_id;
    logic [31:0] i_task_addr;
    logic [31:0] i_reg_word;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [7:0]  o_out_id;
    logic [31:0] o_out_task;
    logic [31:0] o_out_regs;
    logic [4:0]  o_entry_count;
    logic        o_is_empty;

    table_scoreboard sb;
    int   sent;
    bit   stall_enable;
    logic [7:0] used_ids[$];

    task_queue_table i_dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: stalls in random runs, with calm stretches.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!stall_enable) i_stall <= 1'b0;
            else i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Sample accepted result words.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result({o_status, o_out_id, o_out_task, o_out_regs,
                             o_entry_count, o_is_empty});
        end
    end

    // Drive one command word and wait for it to be taken.
    task send_word(logic [2:0] cmd, logic [7:0] id, logic [31:0] taddr, logic [31:0] regs);
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_key_id <= id;
        i_task_addr <= taddr;
        i_reg_word <= regs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_command(cmd, id, taddr, regs);
        if (cmd == CMD_INS_FRONT || cmd == CMD_INS_BACK) used_ids.push_back(id);
        sent++;
        @(negedge i_clk);
    endtask

    // With n of zero, the valid line is left alone.
    task idle_cycles(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task wait_drained();
        if (sb.pending.size() != 0) begin
            i_valid <= 1'b0;
            while (sb.pending.size() != 0) @(negedge i_clk);
        end
    endtask

    // Mostly well-formed commands: ids often taken from ones already inserted.
    task send_random();
        logic [2:0]  cmd;
        logic [7:0]  id;
        logic [31:0] taddr;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) cmd = (pick < 22) ? CMD_INS_FRONT : CMD_INS_BACK;
        else if (pick < 60) cmd = CMD_POP;
        else if (pick < 72) cmd = CMD_FIND;
        else if (pick < 86) cmd = CMD_DELETE;
        else if (pick < 92) cmd = CMD_SORT;
        else if (pick < 98) cmd = CMD_REVERSE;
        else cmd = CMD_UNUSED;
        id = 8'($urandom);
        if ((cmd == CMD_FIND || cmd == CMD_DELETE) && used_ids.size() > 0 &&
            $urandom_range(0, 3) != 0)
            id = used_ids[$urandom_range(0, used_ids.size() - 1)];
        else if ($urandom_range(0, 1)) id = 8'($urandom_range(0, 7));
        // Small address range now and then so that equal sort keys occur.
        taddr = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom;
        send_word(cmd, id, taddr, $urandom);
    endtask

    initial begin
        sb = new();
        sent = 0;
        stall_enable = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_INS_FRONT;
        i_key_id = '0;
        i_task_addr = '0;
        i_reg_word = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: operations on an empty table first.
        send_word(CMD_POP, 8'h00, '0, '0);
        send_word(CMD_FIND, 8'h12, '0, '0);
        send_word(CMD_DELETE, 8'hFF, '0, '0);
        send_word(CMD_SORT, 8'h00, '0, '0);
        send_word(CMD_REVERSE, 8'h00, '0, '0);
        send_word(CMD_UNUSED, 8'hAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Fill to the top with extreme values, then one refused insert.
        for (int i = 0; i < TBL_DEPTH; i++)
            send_word(i[0] ? CMD_INS_BACK : CMD_INS_FRONT, (i == 0) ? 8'hFF : i[7:0],
                      (i < 2) ? 32'hFFFF_FFFF : ((i % 3) == 0 ? 32'h0 : $urandom),
                      i[0] ? 32'hFFFF_FFFF : 32'h0);
        send_word(CMD_INS_BACK, 8'h55, 32'h1234, 32'h5678);
        send_word(CMD_SORT, 8'h00, '0, '0);
        send_word(CMD_REVERSE, 8'h00, '0, '0);
        send_word(CMD_FIND, 8'hFF, '0, '0);
        send_word(CMD_DELETE, 8'h03, '0, '0);
        send_word(CMD_POP, 8'h00, '0, '0);

        // Random part: bursts with gaps, receiver stalls switched on and off.
        for (int b = 0; sent < 820; b++) begin
            stall_enable = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 20)) send_random();
            if (b == 10) wait_drained();
            else idle_cycles($urandom_range(0, 6));
        end

        stall_enable = 1'b0;
        wait_drained();
        idle_cycles(600);
        $display("Sent %0d command words; %0d result words checked over all commands.",
                 sent, sb.checked);
        $display("Covered empty and full tables, equal sort keys and random stalls.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
